// ----- src/cfb_pkg.sv -----
package cfb_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] START_BYTE = 8'hEE;
  localparam logic [7:0] END_BYTE   = 8'hCC;

  localparam int STEP_W = 4;

  // Byte positions inside a header command.
  localparam logic [STEP_W-1:0] HS_SYNC    = 4'd0;
  localparam logic [STEP_W-1:0] HS_START   = 4'd1;
  localparam logic [STEP_W-1:0] HS_TYPE    = 4'd2;
  localparam logic [STEP_W-1:0] HS_NUM_LO  = 4'd3;
  localparam logic [STEP_W-1:0] HS_NUM_HI  = 4'd4;
  localparam logic [STEP_W-1:0] HS_LEN_0   = 4'd5;
  localparam logic [STEP_W-1:0] HS_LEN_1   = 4'd6;
  localparam logic [STEP_W-1:0] HS_LEN_2   = 4'd7;
  localparam logic [STEP_W-1:0] HS_LEN_3   = 4'd8;
  localparam logic [STEP_W-1:0] HS_SUM     = 4'd9;
  localparam logic [STEP_W-1:0] HS_TR_SYNC = 4'd10;
  localparam logic [STEP_W-1:0] HS_TR_END  = 4'd11;

  // Byte positions inside a payload command.
  localparam logic [STEP_W-1:0] PS_DATA    = 4'd0;
  localparam logic [STEP_W-1:0] PS_TR_SYNC = 4'd1;
  localparam logic [STEP_W-1:0] PS_TR_END  = 4'd2;

  localparam logic [0:0] REG_LOWEST  = 1'b0;
  localparam logic [0:0] REG_HIGHEST = 1'b1;

  typedef enum logic {
    CMD_HEADER,
    CMD_PAYLOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;      // type for a header, the byte for a payload
    logic [15:0] number;
    logic [31:0] length;
    logic [7:0]  sum;
    logic        trailer;   // append FF CC after this command
  } cmd_t;

  typedef struct packed {
    logic [7:0] lowest;
    logic [7:0] highest;
  } cfg_t;

endpackage

// ----- src/command_frame_builder.sv -----
// Accepted beats are written into the command queue; the back-end serializer then registers
// the bytes of the head command into the output register. Throughput: one output byte per cycle
// while the queue holds a command and result_stall is low; a payload item yields one byte
// (three when it closes the frame), a start item ten bytes (twelve with an empty payload).
// Items are taken every cycle while the command queue has room.
// Synchronous reset clears the frame state, the queue and the output valid flag.
module command_frame_builder #(
  parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [7:0]  frame_type,
  input  logic [15:0] sequence_number,
  input  logic [31:0] payload_length,
  input  logic [7:0]  payload_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        end_of_frame
);
  import cfb_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic front_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic item_accept;
  logic cfg_write;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;
  assign item_stall  = q_full;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lowest  <= 8'd1;
      cfg.highest <= 8'd255;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LOWEST:  cfg.lowest  <= pwdata[7:0];
        REG_HIGHEST: cfg.highest <= pwdata[7:0];
        default:     cfg.lowest  <= cfg.lowest;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LOWEST:  prdata = {24'd0, cfg.lowest};
      REG_HIGHEST: prdata = {24'd0, cfg.highest};
      default:     prdata = '0;
    endcase
  end

  cfb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (item_accept),
    .func            (func),
    .frame_type      (frame_type),
    .sequence_number (sequence_number),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .push            (front_push),
    .cmd             (front_cmd)
  );

  cfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_cmd),
    .pop   (q_pop),
    .dout  (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  cfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (head_cmd),
    .cmd_ready    (!q_empty),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .end_of_frame (end_of_frame)
  );

endmodule

// ----- src/cfb_front.sv -----
module cfb_front (
  input  logic          clk,
  input  logic          rst,
  input  cfb_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic          func,
  input  logic [7:0]    frame_type,
  input  logic [15:0]   sequence_number,
  input  logic [31:0]   payload_length,
  input  logic [7:0]    payload_byte,
  output logic          push,
  output cfb_pkg::cmd_t cmd
);
  import cfb_pkg::*;

  logic [31:0] bytes_remaining;
  logic        frame_accepted;
  logic        type_ok;
  logic        last_byte;

  assign type_ok   = (frame_type >= cfg.lowest) && (frame_type <= cfg.highest);
  assign last_byte = (bytes_remaining == 32'd1);

  always_comb begin
    cmd = '0;
    push = 1'b0;
    if (!func) begin
      cmd.kind    = CMD_HEADER;
      cmd.data    = frame_type;
      cmd.number  = sequence_number;
      cmd.length  = payload_length;
      cmd.sum     = frame_type + sequence_number[7:0] + sequence_number[15:8]
                  + payload_length[7:0] + payload_length[15:8]
                  + payload_length[23:16] + payload_length[31:24];
      cmd.trailer = (payload_length == 32'd0);
      push        = accept && type_ok;
    end else begin
      cmd.kind    = CMD_PAYLOAD;
      cmd.data    = payload_byte;
      cmd.trailer = last_byte;
      push        = accept && frame_accepted && (bytes_remaining != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      frame_accepted  <= 1'b0;
    end else if (accept) begin
      if (!func) begin
        bytes_remaining <= payload_length;
        frame_accepted  <= type_ok && (payload_length != 32'd0);
      end else if (bytes_remaining != 32'd0) begin
        bytes_remaining <= bytes_remaining - 32'd1;
        if (last_byte) begin
          frame_accepted <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/cfb_queue.sv -----
module cfb_queue #(
  parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfb_pkg::cmd_t din,
  input  logic          pop,
  output cfb_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);
  import cfb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/cfb_back.sv -----
module cfb_back (
  input  logic          clk,
  input  logic          rst,
  input  cfb_pkg::cmd_t cmd,
  input  logic          cmd_ready,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    out_byte,
  output logic          end_of_frame
);
  import cfb_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic [7:0]        cur_byte;
  logic              cur_eof;
  logic              load;

  // The output register takes a new beat when it is empty or being drained.
  assign load = cmd_ready && (!result_valid || !result_stall);
  assign pop  = load && (step == last_step);

  always_comb begin
    cur_byte = SYNC_BYTE;
    cur_eof  = 1'b0;
    if (cmd.kind == CMD_HEADER) begin
      last_step = cmd.trailer ? HS_TR_END : HS_SUM;
      unique case (step)
        HS_SYNC:    cur_byte = SYNC_BYTE;
        HS_START:   cur_byte = START_BYTE;
        HS_TYPE:    cur_byte = cmd.data;
        HS_NUM_LO:  cur_byte = cmd.number[7:0];
        HS_NUM_HI:  cur_byte = cmd.number[15:8];
        HS_LEN_0:   cur_byte = cmd.length[7:0];
        HS_LEN_1:   cur_byte = cmd.length[15:8];
        HS_LEN_2:   cur_byte = cmd.length[23:16];
        HS_LEN_3:   cur_byte = cmd.length[31:24];
        HS_SUM:     cur_byte = cmd.sum;
        HS_TR_SYNC: cur_byte = SYNC_BYTE;
        HS_TR_END: begin
          cur_byte = END_BYTE;
          cur_eof  = 1'b1;
        end
        default:    cur_byte = SYNC_BYTE;
      endcase
    end else begin
      last_step = cmd.trailer ? PS_TR_END : PS_DATA;
      unique case (step)
        PS_DATA:    cur_byte = cmd.data;
        PS_TR_SYNC: cur_byte = SYNC_BYTE;
        PS_TR_END: begin
          cur_byte = END_BYTE;
          cur_eof  = 1'b1;
        end
        default:    cur_byte = SYNC_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
      step         <= pop ? '0 : step + 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= cur_byte;
      end_of_frame <= cur_eof;
    end
  end

endmodule

// ----- test/testbench.sv -----
module testbench;
  import cfb_pkg::*;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic        func;
    logic [7:0]  frame_type;
    logic [15:0] seq_no;
    logic [31:0] length;
    logic [7:0]  data;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        func = FUNC_START;
  logic [7:0]  frame_type = '0;
  logic [15:0] sequence_number = '0;
  logic [31:0] payload_length = '0;
  logic [7:0]  payload_byte = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        end_of_frame;

  // Predictor state and its copy of the type range.
  logic [7:0]  range_lowest = 8'd1;
  logic [7:0]  range_highest = 8'd255;
  logic [31:0] bytes_left = '0;
  logic        frame_open = 1'b0;

  frame_item_t pending_items[$];
  frame_byte_t expected_bytes[$];
  frame_item_t cur_item;
  frame_byte_t want;

  logic send_idle_on = 1'b1;
  logic recv_idle_on = 1'b1;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   hold_requests = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  int mismatches = 0;
  int starts_sent = 0;
  int payloads_sent = 0;
  int bytes_checked = 0;
  int ranges_used = 1;

  command_frame_builder DUT (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .func            (func),
    .frame_type      (frame_type),
    .sequence_number (sequence_number),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .out_byte        (out_byte),
    .end_of_frame    (end_of_frame)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void expect_byte(input logic [7:0] value, input logic last);
    frame_byte_t b;
    b.value = value;
    b.last = last;
    expected_bytes.insert(expected_bytes.size(), b);
  endfunction

  // Works out the bytes that one accepted beat puts on the output.
  function automatic void build_frame_bytes(input frame_item_t it);
    logic [6:0][7:0] hdr;
    logic [7:0]      csum;
    logic            type_ok;
    if (it.func == FUNC_START) begin
      type_ok = (it.frame_type >= range_lowest) && (it.frame_type <= range_highest);
      bytes_left = it.length;
      frame_open = type_ok;
      if (type_ok) begin
        hdr = {it.length, it.seq_no, it.frame_type};
        csum = '0;
        expect_byte(SYNC_BYTE, 1'b0);
        expect_byte(START_BYTE, 1'b0);
        for (int i = 0; i < 7; i++) begin
          csum = csum + hdr[i];
          expect_byte(hdr[i], 1'b0);
        end
        expect_byte(csum, 1'b0);
        if (it.length == 0) begin
          expect_byte(SYNC_BYTE, 1'b0);
          expect_byte(END_BYTE, 1'b1);
          frame_open = 1'b0;
        end
      end
    end else if (bytes_left != 0) begin
      bytes_left = bytes_left - 1;
      if (frame_open) begin
        expect_byte(it.data, 1'b0);
        if (bytes_left == 0) begin
          expect_byte(SYNC_BYTE, 1'b0);
          expect_byte(END_BYTE, 1'b1);
        end
      end
      if (bytes_left == 0) frame_open = 1'b0;
    end
  endfunction

  // Sender: presents one beat at a time from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (item_valid && !item_stall) begin
        build_frame_bytes(cur_item);
        if (cur_item.func == FUNC_START) starts_sent++;
        else payloads_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (send_wait > 0 || pending_items.size() == 0) begin
          item_valid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end else begin
          cur_item = pending_items.pop_front();
          item_valid <= 1'b1;
          func <= cur_item.func;
          frame_type <= cur_item.frame_type;
          sequence_number <= cur_item.seq_no;
          payload_length <= cur_item.length;
          payload_byte <= cur_item.data;
          send_wait = send_idle_on ? $urandom_range(0, 19) : 0;
        end
      end
    end
  end

  // Receiver: checks each output beat and throttles with stall.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (result_valid && !result_stall) begin
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output byte, expected none, got %h (eof %b)",
                   $time, out_byte, end_of_frame);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value) begin
            mismatches++;
            $display("%0t: out_byte expected %h, got %h", $time, want.value, out_byte);
          end
          if (end_of_frame !== want.last) begin
            mismatches++;
            $display("%0t: end_of_frame expected %b, got %b", $time, want.last,
                     end_of_frame);
          end
        end
        recv_wait = recv_idle_on ? $urandom_range(0, 19) : 0;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (hold_left > 0) hold_left--;
      result_stall <= (recv_wait > 0) || (hold_left > 0);
    end
  end

  task automatic reg_write(input logic [0:0] idx, input logic [7:0] value);
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Read the register back in the same selection.
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {24'h0, value}) begin
      mismatches++;
      $display("%0t: register %0d readback expected %h, got %h", $time, idx,
               {24'h0, value}, rd);
    end
  endtask

  task automatic set_type_range(input logic [7:0] lo, input logic [7:0] hi);
    reg_write(REG_LOWEST, lo);
    reg_write(REG_HIGHEST, hi);
    range_lowest = lo;
    range_highest = hi;
    ranges_used++;
    @(negedge clk);
  endtask

  // Waits until every beat is accepted and every byte has come out.
  // Invalid frames give no output, so a quiet stretch follows.
  task automatic drain();
    while (pending_items.size() != 0 || item_valid) @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void add_start(input logic [7:0] t, input logic [15:0] n,
                                    input logic [31:0] len);
    frame_item_t it;
    it.func = FUNC_START;
    it.frame_type = t;
    it.seq_no = n;
    it.length = len;
    it.data = 8'($urandom_range(0, 255));
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_payload(input logic [7:0] b);
    frame_item_t it;
    it.func = FUNC_PAYLOAD;
    it.frame_type = 8'($urandom_range(0, 255));
    it.seq_no = 16'($urandom_range(0, 65535));
    it.length = $urandom();
    it.data = b;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_frame(input logic [7:0] t, input int len);
    add_start(t, 16'($urandom_range(0, 65535)), len);
    for (int k = 0; k < len; k++) add_payload(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] pick_type(input logic want_valid);
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    if (want_valid) begin
      if (range_lowest <= range_highest)
        t = 8'($urandom_range(int'(range_highest), int'(range_lowest)));
    end else if (!(range_lowest == 0 && range_highest == 255)) begin
      while (t >= range_lowest && t <= range_highest) t = 8'($urandom_range(0, 255));
    end
    return t;
  endfunction

  // Mostly complete frames; also swallowed frames, stray bytes and frames
  // cut short by a new start. Every sequence leaves no frame open.
  function automatic void add_traffic(input int target);
    int added;
    int pick;
    int len;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        add_frame(pick_type(1'b1), len);
        added += len + 1;
      end else if (pick < 16) begin
        len = $urandom_range(0, 4);
        add_frame(pick_type(1'b0), len);
        added += len + 1;
      end else if (pick < 18) begin
        add_payload(8'($urandom_range(0, 255)));
        added += 1;
      end else begin
        len = $urandom_range(0, 3);
        add_start(pick_type(logic'($urandom_range(0, 1))), 16'($urandom_range(0, 65535)),
                  $urandom());
        for (int k = 0; k < len; k++) add_payload(8'($urandom_range(0, 255)));
        added += len + 1;
        len = $urandom_range(1, 6);
        add_frame(pick_type(1'b1), len);
        added += len + 1;
      end
    end
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats under the reset range of 1 to 255.
    add_start(8'h00, 16'h0001, 32'd2);       // type below range, bytes swallowed
    add_payload(8'h00);
    add_payload(8'hFF);
    add_payload(8'h5A);                      // stray byte outside any frame
    add_start(8'h01, 16'h0000, 32'd0);       // empty payload, trailer at once
    add_start(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_payload(8'hFF);
    add_payload(8'h00);
    add_start(8'h80, 16'h1234, 32'd3);       // abandons the frame above
    add_payload(8'h00);
    add_payload(8'hFF);
    add_payload(8'hA5);
    add_start(8'h00, 16'hFFFF, 32'd0);       // invalid and empty
    add_start(8'h7E, 16'hABCD, 32'd1);
    add_payload(8'h3C);
    add_start(8'h00, 16'h0000, 32'd5);       // swallowed frame cut short
    add_payload(8'h11);
    add_start(8'h02, 16'h5555, 32'h8000_0001);
    add_start(8'h03, 16'hAAAA, 32'd2);
    add_payload(8'h81);
    add_payload(8'h7E);
    drain();

    set_type_range(8'd0, 8'd255);
    add_traffic(60);
    drain();

    set_type_range(8'd255, 8'd255);
    add_traffic(35);
    drain();

    // Sender without gaps while the receiver holds off for a long stretch.
    set_type_range(8'd50, 8'd180);
    send_idle_on = 1'b0;
    add_traffic(60);
    hold_requests++;
    drain();

    set_type_range(8'd0, 8'd0);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b0;
    add_traffic(30);
    drain();

    // Empty range: nothing is valid.
    set_type_range(8'd200, 8'd100);
    recv_idle_on = 1'b1;
    add_traffic(30);
    drain();

    set_type_range(8'd1, 8'd255);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    add_traffic(35);
    drain();

    $display("Run covered %0d frame starts and %0d payload beats under %0d type ranges,",
             starts_sent, payloads_sent, ranges_used);
    $display("checking %0d output bytes with %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
